// ===== rtl/fdrt_pkg.sv =====
// Shared types and constants for the fence deferred release tracker.
// No dependencies; the other files in rtl/ except fdrt_entry_ram refer to this package by scoped names.
package fdrt_pkg;

	localparam int FRAME_SLOTS = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int HANDLE_BITS = 16;

	localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = HANDLE_BITS + FRAME_SLOTS;

	typedef logic [1:0]             req_kind_t;
	typedef logic [1:0]             slot_field_t;
	typedef logic [15:0]            handle_field_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [FRAME_SLOTS-1:0] slot_mask_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [IDX_W-1:0]       idx_t;

	localparam req_kind_t REQ_DEFER    = 2'd0;
	localparam req_kind_t REQ_SUBMIT   = 2'd1;
	localparam req_kind_t REQ_COMPLETE = 2'd2;
	localparam req_kind_t REQ_SHUTDOWN = 2'd3;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		req_kind_t     req_type;
		slot_field_t   slot;
		handle_field_t handle;
	} req_t;

	typedef struct packed {
		logic          released;
		handle_field_t released_handle;
		logic          last;
		logic          status;
	} rsp_t;

	// one pending queue entry as stored in the entry memory
	typedef struct packed {
		handle_t    handle;
		slot_mask_t mask;
	} entry_t;

	// result word handed from the sequencer to the output register
	typedef struct packed {
		logic valid;
		rsp_t word;
	} push_t;

endpackage

// ===== rtl/fdrt_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on fdrt_pkg for the word types.
interface fdrt_req_if;
	logic          valid;
	logic          ready;
	fdrt_pkg::req_t word;
	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

interface fdrt_rsp_if;
	logic          valid;
	logic          ready;
	fdrt_pkg::rsp_t word;
	modport source(output valid, output word, input ready);
	modport sink(input valid, input word, output ready);
endinterface

// ===== rtl/fdrt_entry_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// Standalone; sized by its parameters.
module fdrt_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 20
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/fdrt_sweep_ctrl.sv =====
// Request decoder and release sweep sequencer for the tracker.
// Depends on fdrt_pkg and fdrt_if; drives the entry RAM ports.
module fdrt_sweep_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	fdrt_req_if.sink             req,
	input  logic                 out_free,
	output fdrt_pkg::push_t      push,
	output logic                 wr_en,
	output fdrt_pkg::idx_t       wr_addr,
	output fdrt_pkg::entry_t     wr_data,
	output logic                 rd_en,
	output fdrt_pkg::idx_t       rd_addr,
	input  fdrt_pkg::entry_t     rd_data
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	logic                 state_q;
	fdrt_pkg::cnt_t       count_q;
	fdrt_pkg::slot_mask_t busy_q;
	logic                 shut_q;
	fdrt_pkg::slot_mask_t clr_q;
	fdrt_pkg::cnt_t       rd_idx_q;
	fdrt_pkg::cnt_t       keep_q;
	logic                 valid_s1;
	logic                 hold_valid_q;
	fdrt_pkg::handle_t    hold_handle_q;

	logic                 accept;
	logic                 slot_ok;
	logic                 full;
	fdrt_pkg::slot_mask_t slot_bit;
	fdrt_pkg::slot_mask_t s1_mask;
	logic                 s1_rel;
	logic                 stall;
	logic                 issue;
	logic                 finish;

	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign slot_ok   = int'(req.word.slot) < fdrt_pkg::FRAME_SLOTS;
	assign slot_bit  = fdrt_pkg::slot_mask_t'(1) << req.word.slot;
	assign full      = count_q == fdrt_pkg::cnt_t'(fdrt_pkg::QUEUE_DEPTH);

	assign s1_mask = rd_data.mask & ~clr_q;
	assign s1_rel  = valid_s1 && (s1_mask == '0);
	// a second release needs the held one drained first
	assign stall   = (state_q == ST_SWEEP) && s1_rel && hold_valid_q && !out_free;
	assign issue   = (state_q == ST_SWEEP) && !stall && (rd_idx_q != count_q);
	assign finish  = (state_q == ST_SWEEP) && !valid_s1 && (rd_idx_q == count_q) && out_free;

	always_comb begin
		push    = '0;
		wr_en   = 1'b0;
		wr_addr = keep_q[fdrt_pkg::IDX_W-1:0];
		wr_data = '{handle: rd_data.handle, mask: s1_mask};
		rd_en   = issue;
		rd_addr = rd_idx_q[fdrt_pkg::IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.word.req_type)
						fdrt_pkg::REQ_DEFER: begin
							push.valid     = 1'b1;
							push.word.last = 1'b1;
							if (shut_q) begin
								push.word.released        = 1'b1;
								push.word.released_handle = req.word.handle;
							end else if (full) begin
								push.word.status = fdrt_pkg::STATUS_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[fdrt_pkg::IDX_W-1:0];
								wr_data = '{handle: fdrt_pkg::handle_t'(req.word.handle),
								            mask: busy_q};
							end
						end
						fdrt_pkg::REQ_SUBMIT: begin
							push.valid     = 1'b1;
							push.word.last = 1'b1;
						end
						fdrt_pkg::REQ_COMPLETE: begin
							push.valid     = !slot_ok;
							push.word.last = 1'b1;
						end
						default: begin
							push.valid     = shut_q;
							push.word.last = 1'b1;
						end
					endcase
				end
			end
			default: begin
				if (valid_s1 && !s1_rel) begin
					wr_en = 1'b1;
				end
				if (s1_rel && hold_valid_q && !stall) begin
					push.valid                = 1'b1;
					push.word.released        = 1'b1;
					push.word.released_handle = 16'(hold_handle_q);
				end
				if (finish) begin
					push.valid                = 1'b1;
					push.word.last            = 1'b1;
					push.word.released        = hold_valid_q;
					push.word.released_handle = hold_valid_q ? 16'(hold_handle_q) : '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			busy_q       <= '0;
			shut_q       <= 1'b0;
			rd_idx_q     <= '0;
			keep_q       <= '0;
			valid_s1     <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.word.req_type)
							fdrt_pkg::REQ_DEFER: begin
								if (!shut_q && !full) begin
									count_q <= count_q + 1'b1;
								end
							end
							fdrt_pkg::REQ_SUBMIT: begin
								if (slot_ok) begin
									busy_q <= busy_q | slot_bit;
								end
							end
							fdrt_pkg::REQ_COMPLETE: begin
								if (slot_ok) begin
									busy_q   <= busy_q & ~slot_bit;
									state_q  <= ST_SWEEP;
									rd_idx_q <= '0;
									keep_q   <= '0;
								end
							end
							default: begin
								if (!shut_q) begin
									shut_q   <= 1'b1;
									busy_q   <= '0;
									state_q  <= ST_SWEEP;
									rd_idx_q <= '0;
									keep_q   <= '0;
								end
							end
						endcase
					end
				end
				default: begin
					if (!stall) begin
						valid_s1 <= issue;
						if (issue) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
						if (valid_s1 && !s1_rel) begin
							keep_q <= keep_q + 1'b1;
						end
						if (s1_rel) begin
							hold_valid_q <= 1'b1;
						end
					end
					if (finish) begin
						state_q      <= ST_IDLE;
						count_q      <= keep_q;
						hold_valid_q <= 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// shutdown clears every wait bit, so all entries release
			clr_q <= (req.word.req_type == fdrt_pkg::REQ_SHUTDOWN) ? '1 : slot_bit;
		end
		if ((state_q == ST_SWEEP) && !stall && s1_rel) begin
			hold_handle_q <= rd_data.handle;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fdrt_pkg::cnt_t'(fdrt_pkg::QUEUE_DEPTH))
		else $error("pending count above queue depth");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (keep_q <= rd_idx_q))
		else $error("compaction pointer ahead of read pointer");

	a_write_below_read: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SWEEP) && wr_en) |-> (keep_q < rd_idx_q))
		else $error("sweep write overlaps unread entry");

	a_shut_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && shut_q) |-> (count_q == '0))
		else $error("entries pending after shutdown");

	a_sweep_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !accept)
		else $error("request taken during sweep");

endmodule

// ===== rtl/fence_deferred_release_tracker_top.sv =====
// Top level of the fence deferred release tracker.
// Depends on fdrt_pkg, fdrt_if, fdrt_entry_ram and fdrt_sweep_ctrl.
//
// Usage:
//   req carries one request word (req_type, slot, handle); rsp returns result
//   words (released, released_handle, last, status). Both are valid/ready; a
//   word moves on a rising edge with valid and ready high.
//   Every request gives at least one result word; the last one has last = 1.
//   Defer, submit, ignored complete and repeated shutdown answer one word,
//   visible on rsp in the cycle after acceptance.
//   A valid complete or the first shutdown starts a sweep of the entry RAM:
//   one entry read per cycle except while a release waits on a full output,
//   through the registered read port, survivors written back compacted in
//   age order.
//   Released handles go out one per word, oldest first.
//   One request is in the block at a time: req.ready is low during a sweep and
//   whenever the output register holds a word the receiver does not take.
//   A stalled receiver freezes the sweep; nothing is lost or repeated.
//   Reset (arst_n low) empties the queue, clears the busy mask and the
//   shutdown flag; the RAM contents are not cleared and need no clearing.
module fence_deferred_release_tracker_top (
	input  logic         clk,
	input  logic         arst_n,
	fdrt_req_if.sink     req,
	fdrt_rsp_if.source   rsp
);

	fdrt_pkg::push_t  push;
	logic             out_free;
	logic             wr_en;
	fdrt_pkg::idx_t   wr_addr;
	fdrt_pkg::entry_t wr_data;
	logic             rd_en;
	fdrt_pkg::idx_t   rd_addr;
	fdrt_pkg::entry_t rd_data;

	logic             out_valid_q;
	fdrt_pkg::rsp_t   out_word_q;

	fdrt_sweep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.push     (push),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	fdrt_entry_ram #(
		.DEPTH (fdrt_pkg::QUEUE_DEPTH),
		.WIDTH (fdrt_pkg::ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register: free when empty or being drained this cycle
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the word while the receiver stalls
	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_word_q <= push.word;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> out_free)
		else $error("result word pushed into a full output register");

	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !push.word.released) |-> (push.word.released_handle == '0))
		else $error("acknowledge carries a handle");

	a_full_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.word.status) |-> (push.word.last && !push.word.released))
		else $error("reject word malformed");

endmodule

// ===== test/fence_deferred_release_tracker_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fence_deferred_release_tracker_top.
// Depends on fdrt_pkg and fdrt_if from rtl/; drives requests, predicts and checks result words.
module fence_deferred_release_tracker_top_tb;
	import fdrt_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 40;
	localparam int          BLOCKS         = 11;
	localparam int          BLOCK_ITEMS    = 30;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	// Mirror of the tracker: pending handles in age order with their wait
	// masks, the busy-slot mask and the shutdown flag. Every accepted request
	// turns into its result words, which wait here until the block sends them.
	class release_scoreboard;
		handle_t    held_handle[$];
		slot_mask_t held_mask[$];
		slot_mask_t busy;
		bit         is_shut;
		rsp_t       expected_words[$];
		int         mismatches;

		function new();
			busy       = '0;
			is_shut    = 1'b0;
			mismatches = 0;
		endfunction

		function void push_word(logic rel, handle_field_t h, logic st);
			rsp_t w;
			w.released        = rel;
			w.released_handle = h;
			w.last            = 1'b0;
			w.status          = st;
			expected_words = {expected_words, w};
		endfunction

		function void note_request(req_t r);
			int         first;
			slot_mask_t clr;
			slot_mask_t m;
			handle_t    kept_h[$];
			slot_mask_t kept_m[$];
			first = expected_words.size();
			case (r.req_type)
				REQ_DEFER: begin
					if (is_shut) begin
						push_word(1'b1, r.handle, STATUS_OK);
					end else if (held_handle.size() >= QUEUE_DEPTH) begin
						push_word(1'b0, '0, STATUS_FULL);
					end else begin
						held_handle = {held_handle, handle_t'(r.handle)};
						held_mask   = {held_mask, busy};
						push_word(1'b0, '0, STATUS_OK);
					end
				end
				REQ_SUBMIT: begin
					if (int'(r.slot) < FRAME_SLOTS)
						busy = busy | (slot_mask_t'(1) << r.slot);
				end
				REQ_COMPLETE: begin
					if (int'(r.slot) < FRAME_SLOTS) begin
						clr  = ~(slot_mask_t'(1) << r.slot);
						busy = busy & clr;
						foreach (held_handle[i]) begin
							m = held_mask[i] & clr;
							if (m == '0) begin
								push_word(1'b1, handle_field_t'(held_handle[i]), STATUS_OK);
							end else begin
								kept_h = {kept_h, held_handle[i]};
								kept_m = {kept_m, m};
							end
						end
						held_handle = kept_h;
						held_mask   = kept_m;
					end
				end
				default: begin
					if (!is_shut) begin
						is_shut = 1'b1;
						busy    = '0;
						foreach (held_handle[i])
							push_word(1'b1, handle_field_t'(held_handle[i]), STATUS_OK);
						held_handle.delete();
						held_mask.delete();
					end
				end
			endcase
			if (expected_words.size() == first)
				push_word(1'b0, '0, STATUS_OK);
			expected_words[expected_words.size() - 1].last = 1'b1;
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_words.size() == 0) begin
				$display({"%0t: unexpected word, expected none, ",
					"actual released=%0b handle=%h last=%0b status=%0b"},
					$time, got.released, got.released_handle, got.last, got.status);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			check_field("released", 16'(want.released), 16'(got.released));
			check_field("released_handle", want.released_handle, got.released_handle);
			check_field("last", 16'(want.last), 16'(got.last));
			check_field("status", 16'(want.status), 16'(got.status));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fdrt_req_if req_ch();
	fdrt_rsp_if rsp_ch();

	fence_deferred_release_tracker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	release_scoreboard sb;
	bit                quiet_phase;   // both sides skip their gaps while set
	int unsigned       stall_cycles;  // cycles since the last word moved on either side

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample both channels at the rising edge: note accepted requests first so
	// their expected words exist before any result is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.word);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.word);
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Receiver: hold ready low for a random gap before each word, then take it.
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = quiet_phase ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// Present one request after a random gap and hold it until accepted.
	// Called and returning at a falling edge; valid stays high when the next
	// request follows with no gap.
	task automatic send_request(req_kind_t kind, slot_field_t s, handle_field_t h);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.word.req_type = kind;
		req_ch.word.slot     = s;
		req_ch.word.handle   = h;
		req_ch.valid         = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		mix_t      mix;
		int        roll;
		int        defer_top;
		int        submit_top;
		req_kind_t kind;

		sb           = new();
		quiet_phase  = 1'b0;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.word  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. An entry deferred with an empty mask leaves on the
		// next completion, even of an idle slot; completion on an empty queue
		// only acknowledges.
		send_request(REQ_DEFER, 2'd0, 16'h0000);
		send_request(REQ_COMPLETE, 2'd3, 16'h0000);
		send_request(REQ_COMPLETE, 2'd0, 16'hFFFF);
		// All slots busy, then entries that wait on several slots.
		send_request(REQ_SUBMIT, 2'd0, 16'h0000);
		send_request(REQ_SUBMIT, 2'd1, 16'h0000);
		send_request(REQ_SUBMIT, 2'd2, 16'h0000);
		send_request(REQ_SUBMIT, 2'd3, 16'hFFFF);
		send_request(REQ_DEFER, 2'd3, 16'hFFFF);
		send_request(REQ_DEFER, 2'd0, 16'h5A5A);
		send_request(REQ_COMPLETE, 2'd1, 16'h0000);
		send_request(REQ_COMPLETE, 2'd0, 16'h0000);
		send_request(REQ_COMPLETE, 2'd2, 16'h0000);
		send_request(REQ_DEFER, 2'd1, 16'hA5A5);
		// Last slot clears: release three entries oldest first.
		send_request(REQ_COMPLETE, 2'd3, 16'h0000);
		// Repeated submit of a busy slot, then its completion.
		send_request(REQ_SUBMIT, 2'd2, 16'h0000);
		send_request(REQ_DEFER, 2'd2, 16'h1234);
		send_request(REQ_SUBMIT, 2'd2, 16'hFFFF);
		send_request(REQ_COMPLETE, 2'd2, 16'h0000);

		// Random part before shutdown. Each block picks one of filling the
		// queue (reaching the full-queue reject), draining and an even mix;
		// some blocks run with no gaps on either side.
		for (int blk = 0; blk < BLOCKS; blk++) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			mix = (blk == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
			case (mix)
				MIX_FILL: begin
					defer_top  = 70;
					submit_top = 85;
				end
				MIX_DRAIN: begin
					defer_top  = 25;
					submit_top = 55;
				end
				default: begin
					defer_top  = 40;
					submit_top = 65;
				end
			endcase
			for (int k = 0; k < BLOCK_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < defer_top)
					kind = REQ_DEFER;
				else if (roll < submit_top)
					kind = REQ_SUBMIT;
				else
					kind = REQ_COMPLETE;
				send_request(kind, slot_field_t'($urandom_range(0, 3)),
					handle_field_t'($urandom_range(0, 65535)));
			end
		end

		// Make sure shutdown finds entries still waiting.
		quiet_phase = 1'b0;
		send_request(REQ_SUBMIT, 2'd1, 16'h0000);
		send_request(REQ_DEFER, 2'd0, 16'hBEEF);
		send_request(REQ_DEFER, 2'd3, 16'h0001);
		send_request(REQ_DEFER, 2'd1, 16'h8000);
		send_request(REQ_SHUTDOWN, 2'd0, 16'h0000);
		// After shutdown: defers release at once, submits only touch the mask,
		// further shutdowns acknowledge.
		send_request(REQ_SHUTDOWN, 2'd3, 16'hFFFF);
		for (int k = 0; k < BLOCK_ITEMS; k++) begin
			if (k == BLOCK_ITEMS / 2)
				quiet_phase = 1'b1;
			send_request(req_kind_t'($urandom_range(0, 3)), slot_field_t'($urandom_range(0, 3)),
				handle_field_t'($urandom_range(0, 65535)));
		end
		quiet_phase  = 1'b0;
		req_ch.valid = 1'b0;

		// Drain the outstanding words, then watch a little longer for extras.
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== fence_deferred_release_tracker_top.f =====
rtl/fdrt_pkg.sv
rtl/fdrt_if.sv
rtl/fdrt_entry_ram.sv
rtl/fdrt_sweep_ctrl.sv
rtl/fence_deferred_release_tracker_top.sv
test/fence_deferred_release_tracker_top_tb.sv
